// ===== sv/ltm_pkg.sv =====
package ltm_pkg;

  localparam int unsigned RTT_SLOTS_DEF = 64;

  // operation codes
  localparam logic [1:0] OP_RECV  = 2'd0;
  localparam logic [1:0] OP_SEND  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [7:0] MAGIC_L = 8'h4C;
  localparam logic [7:0] TYPE_T  = 8'h54;
  localparam logic [7:0] TYPE_E  = 8'h45;
  localparam logic [7:0] TYPE_R  = 8'h52;

  localparam logic [7:0] LEN_TEST_MIN = 8'd2;
  localparam logic [7:0] LEN_NUM_MIN  = 8'd6;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    ST_APP       = 3'd0,
    ST_COUNTED   = 3'd1,
    ST_ECHO_DUE  = 3'd2,
    ST_MATCHED   = 3'd3,
    ST_UNMATCHED = 3'd4,
    ST_SHORT     = 3'd5,
    ST_SENT      = 3'd6,
    ST_CLEARED   = 3'd7
  } status_e;

  // classified beat handed from front to back
  typedef struct packed {
    status_e     status;
    logic [31:0] seq;
    logic [31:0] rtt;
  } ltm_entry_t;

endpackage

// ===== sv/ltm_front.sv =====
module ltm_front #(
  parameter int unsigned RTT_SLOTS = ltm_pkg::RTT_SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [7:0]         frame_length_i,
  input  logic [7:0]         magic_byte_i,
  input  logic [7:0]         frame_type_i,
  input  logic [31:0]        sequence_in_i,
  input  logic [31:0]        now_us_i,
  output logic               push_valid_o,
  output ltm_pkg::ltm_entry_t push_entry_o,
  input  logic               q_full_i
);

  localparam int unsigned IDX_W = $clog2(RTT_SLOTS);
  localparam int unsigned SHIFT = 32 + IDX_W;
  // ceil(2^SHIFT / RTT_SLOTS) gives an exact quotient for any 32-bit key
  localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'(RTT_SLOTS) - 64'd1)
                                  / 64'(RTT_SLOTS);
  localparam logic [32:0] RECIP33 = RECIP[32:0];
  localparam logic [31:0] SLOTS32 = 32'(RTT_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RTT_SLOTS - 1);

  typedef struct packed {
    ltm_pkg::status_e status;
    logic [31:0]      key;
    logic [31:0]      now;
  } item_t;

  logic             clr_busy_q;
  logic [IDX_W-1:0] clr_idx_q;
  logic [31:0]      send_seq_q;

  logic             adv;
  logic             accept;
  logic             v0_d;
  item_t            item0_d;

  logic             v0_q, v1_q, v2_q, v3_q;
  item_t            it0_q, it1_q, it2_q, it3_q;
  logic [31:0]      quot1_q;
  logic [IDX_W-1:0] slot2_q;
  logic [64:0]      prod;
  logic [31:0]      rem;
  logic [63:0]      rd_q;
  logic             hit;

  logic [63:0]      mem [RTT_SLOTS];

  assign adv        = !v3_q || !q_full_i;
  assign in_ready_o = !clr_busy_q && adv;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    v0_d           = 1'b1;
    item0_d.status = ltm_pkg::ST_APP;
    item0_d.key    = sequence_in_i;
    item0_d.now    = now_us_i;
    case (operation_i)
      ltm_pkg::OP_RECV: begin
        if (frame_length_i < ltm_pkg::LEN_TEST_MIN || magic_byte_i != ltm_pkg::MAGIC_L ||
            !(frame_type_i inside {ltm_pkg::TYPE_T, ltm_pkg::TYPE_E, ltm_pkg::TYPE_R})) begin
          item0_d.status = ltm_pkg::ST_APP;
        end else if (frame_length_i < ltm_pkg::LEN_NUM_MIN) begin
          item0_d.status = ltm_pkg::ST_SHORT;
        end else if (frame_type_i == ltm_pkg::TYPE_R) begin
          // resolved against the slot table three stages on
          item0_d.status = ltm_pkg::ST_MATCHED;
        end else if (frame_type_i == ltm_pkg::TYPE_E) begin
          item0_d.status = ltm_pkg::ST_ECHO_DUE;
        end else begin
          item0_d.status = ltm_pkg::ST_COUNTED;
        end
      end
      ltm_pkg::OP_SEND: begin
        item0_d.status = ltm_pkg::ST_SENT;
        item0_d.key    = send_seq_q + 32'd1;
      end
      ltm_pkg::OP_CLEAR: begin
        item0_d.status = ltm_pkg::ST_CLEARED;
      end
      default: begin
        v0_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
      send_seq_q <= '0;
      v0_q       <= 1'b0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == LAST_IDX) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (accept && operation_i == ltm_pkg::OP_SEND) begin
        send_seq_q <= send_seq_q + 32'd1;
      end
      if (adv) begin
        v0_q <= accept && v0_d;
        v1_q <= v0_q;
        v2_q <= v1_q;
        v3_q <= v2_q;
      end
    end
  end

  // slot = key mod RTT_SLOTS via reciprocal multiply, then subtract
  assign prod = {33'd0, it0_q.key} * {32'd0, RECIP33};
  assign rem  = it1_q.key - 32'(quot1_q * SLOTS32);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it0_q   <= item0_d;
      it1_q   <= it0_q;
      quot1_q <= 32'(prod >> SHIFT);
      it2_q   <= it1_q;
      slot2_q <= rem[IDX_W-1:0];
      it3_q   <= it2_q;
    end
  end

  // slot table: reads and writes in one stage keep beat order
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_idx_q] <= '0;
    end else if (adv && v2_q && it2_q.status == ltm_pkg::ST_SENT) begin
      mem[slot2_q] <= {it2_q.key, it2_q.now};
    end
    if (adv) begin
      rd_q <= mem[slot2_q];
    end
  end

  assign hit = (rd_q[63:32] == it3_q.key);

  always_comb begin
    push_entry_o.status = it3_q.status;
    push_entry_o.seq    = it3_q.key;
    push_entry_o.rtt    = '0;
    if (it3_q.status == ltm_pkg::ST_MATCHED) begin
      if (hit) begin
        push_entry_o.rtt = it3_q.now - rd_q[31:0];
      end else begin
        push_entry_o.status = ltm_pkg::ST_UNMATCHED;
      end
    end
  end

  assign push_valid_o = v3_q;

endmodule

// ===== sv/ltm_queue.sv =====
module ltm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  input  ltm_pkg::ltm_entry_t push_entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output ltm_pkg::ltm_entry_t pop_entry_o
);

  localparam logic [ltm_pkg::QPTR_W-1:0] PTR_LAST = ltm_pkg::QPTR_W'(ltm_pkg::QDEPTH - 1);
  localparam logic [ltm_pkg::QCNT_W-1:0] CNT_FULL = ltm_pkg::QCNT_W'(ltm_pkg::QDEPTH);

  ltm_pkg::ltm_entry_t             slots_q [ltm_pkg::QDEPTH];
  logic [ltm_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [ltm_pkg::QCNT_W-1:0]      cnt_q;
  logic                            push, pop;

  assign full_o      = (cnt_q == CNT_FULL);
  assign empty_o     = (cnt_q == '0);
  assign push        = push_valid_i && !full_o;
  assign pop         = pop_i && !empty_o;
  assign pop_entry_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== sv/ltm_back.sv =====
module ltm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  ltm_pkg::ltm_entry_t entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic [31:0]         sequence_out_o,
  output logic [31:0]         round_trip_us_o,
  output logic [31:0]         received_count_o,
  output logic [31:0]         test_received_count_o,
  output logic [31:0]         lost_count_o,
  output logic [31:0]         echo_count_o,
  output logic [63:0]         rtt_total_us_o,
  output logic [31:0]         rtt_least_us_o,
  output logic [31:0]         rtt_most_us_o,
  output logic [31:0]         test_sent_count_o
);

  logic        out_valid_q;
  logic [2:0]  status_q;
  logic [31:0] seq_out_q, rtt_out_q;

  logic [31:0] rcvd_q, rcvd_d, tests_q, tests_d, lost_q, lost_d, echo_q, echo_d;
  logic [31:0] min_q, min_d, max_q, max_d, sent_q, sent_d, last_q, last_d;
  logic [63:0] sum_q, sum_d;
  logic        have_q, have_d;
  logic [31:0] last_inc;

  assign pop_o    = !empty_i && (!out_valid_q || out_ready_i);
  assign last_inc = last_q + 32'd1;

  always_comb begin
    rcvd_d  = rcvd_q;
    tests_d = tests_q;
    lost_d  = lost_q;
    echo_d  = echo_q;
    sum_d   = sum_q;
    min_d   = min_q;
    max_d   = max_q;
    sent_d  = sent_q;
    last_d  = last_q;
    have_d  = have_q;
    case (entry_i.status)
      ltm_pkg::ST_APP, ltm_pkg::ST_SHORT, ltm_pkg::ST_UNMATCHED: begin
        rcvd_d = rcvd_q + 32'd1;
      end
      ltm_pkg::ST_COUNTED, ltm_pkg::ST_ECHO_DUE: begin
        rcvd_d  = rcvd_q + 32'd1;
        tests_d = tests_q + 32'd1;
        if (have_q && entry_i.seq > last_inc) begin
          lost_d = lost_q + (entry_i.seq - last_inc);
        end
        // advance the mark only forward
        if (!have_q || entry_i.seq > last_q) begin
          last_d = entry_i.seq;
          have_d = 1'b1;
        end
      end
      ltm_pkg::ST_MATCHED: begin
        rcvd_d = rcvd_q + 32'd1;
        echo_d = echo_q + 32'd1;
        sum_d  = sum_q + {32'd0, entry_i.rtt};
        if (min_q == '0 || entry_i.rtt < min_q) begin
          min_d = entry_i.rtt;
        end
        if (entry_i.rtt > max_q) begin
          max_d = entry_i.rtt;
        end
      end
      ltm_pkg::ST_SENT: begin
        sent_d = sent_q + 32'd1;
      end
      ltm_pkg::ST_CLEARED: begin
        rcvd_d  = '0;
        tests_d = '0;
        lost_d  = '0;
        echo_d  = '0;
        sum_d   = '0;
        min_d   = '0;
        max_d   = '0;
        sent_d  = '0;
        have_d  = 1'b0;
      end
      default: begin
        rcvd_d = rcvd_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rcvd_q      <= '0;
      tests_q     <= '0;
      lost_q      <= '0;
      echo_q      <= '0;
      sum_q       <= '0;
      min_q       <= '0;
      max_q       <= '0;
      sent_q      <= '0;
      last_q      <= '0;
      have_q      <= 1'b0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        rcvd_q      <= rcvd_d;
        tests_q     <= tests_d;
        lost_q      <= lost_d;
        echo_q      <= echo_d;
        sum_q       <= sum_d;
        min_q       <= min_d;
        max_q       <= max_d;
        sent_q      <= sent_d;
        last_q      <= last_d;
        have_q      <= have_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q  <= entry_i.status;
      seq_out_q <= (entry_i.status == ltm_pkg::ST_ECHO_DUE ||
                    entry_i.status == ltm_pkg::ST_SENT) ? entry_i.seq : '0;
      rtt_out_q <= entry_i.rtt;
    end
  end

  // statistics only move when a new beat is loaded, so they stand as outputs
  assign out_valid_o           = out_valid_q;
  assign status_o              = status_q;
  assign sequence_out_o        = seq_out_q;
  assign round_trip_us_o       = rtt_out_q;
  assign received_count_o      = rcvd_q;
  assign test_received_count_o = tests_q;
  assign lost_count_o          = lost_q;
  assign echo_count_o          = echo_q;
  assign rtt_total_us_o        = sum_q;
  assign rtt_least_us_o        = min_q;
  assign rtt_most_us_o         = max_q;
  assign test_sent_count_o     = sent_q;

endmodule

// ===== sv/link_test_loss_rtt_monitor_top.sv =====
// Link test monitor: one beat in per cycle while in_ready_o is high, one result
// beat out per received frame, send or clear (operation 3 is taken and dropped).
// The front classifies the beat, reduces the sequence to a slot index in two
// multiply stages and accesses the slot table in a third; a result then passes the
// two-entry queue and the output register. After reset the slot table is zeroed
// one entry a cycle, with in_ready_o low until the last entry is cleared. Statistics
// ports always show the counters after the beat on the output.
module link_test_loss_rtt_monitor_top #(
  parameter int unsigned RTT_SLOTS = ltm_pkg::RTT_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  frame_length_i,
  input  logic [7:0]  magic_byte_i,
  input  logic [7:0]  frame_type_i,
  input  logic [31:0] sequence_in_i,
  input  logic [31:0] now_us_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] sequence_out_o,
  output logic [31:0] round_trip_us_o,
  output logic [31:0] received_count_o,
  output logic [31:0] test_received_count_o,
  output logic [31:0] lost_count_o,
  output logic [31:0] echo_count_o,
  output logic [63:0] rtt_total_us_o,
  output logic [31:0] rtt_least_us_o,
  output logic [31:0] rtt_most_us_o,
  output logic [31:0] test_sent_count_o
);

  logic                push_valid;
  ltm_pkg::ltm_entry_t push_entry;
  logic                q_full;
  logic                q_empty;
  logic                pop;
  ltm_pkg::ltm_entry_t pop_entry;

  ltm_front #(
    .RTT_SLOTS(RTT_SLOTS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .frame_length_i (frame_length_i),
    .magic_byte_i   (magic_byte_i),
    .frame_type_i   (frame_type_i),
    .sequence_in_i  (sequence_in_i),
    .now_us_i       (now_us_i),
    .push_valid_o   (push_valid),
    .push_entry_o   (push_entry),
    .q_full_i       (q_full)
  );

  ltm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .empty_o      (q_empty),
    .pop_entry_o  (pop_entry)
  );

  ltm_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .empty_i               (q_empty),
    .entry_i               (pop_entry),
    .pop_o                 (pop),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .status_o              (status_o),
    .sequence_out_o        (sequence_out_o),
    .round_trip_us_o       (round_trip_us_o),
    .received_count_o      (received_count_o),
    .test_received_count_o (test_received_count_o),
    .lost_count_o          (lost_count_o),
    .echo_count_o          (echo_count_o),
    .rtt_total_us_o        (rtt_total_us_o),
    .rtt_least_us_o        (rtt_least_us_o),
    .rtt_most_us_o         (rtt_most_us_o),
    .test_sent_count_o     (test_sent_count_o)
  );

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rtt_least_us_o != 32'd0) |-> (rtt_least_us_o <= rtt_most_us_o))
    else $error("rtt minimum above maximum");

  a_rtt_only_on_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ltm_pkg::ST_MATCHED) |-> (round_trip_us_o == 32'd0))
    else $error("round trip on a beat that is not a matched echo");

  a_seq_only_when_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ltm_pkg::ST_ECHO_DUE && status_o != ltm_pkg::ST_SENT)
    |-> (sequence_out_o == 32'd0))
    else $error("sequence out on a beat without echo or send");

  a_pop_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (!q_empty && (!out_valid_o || out_ready_i)))
    else $error("queue popped while output held");

endmodule

// ===== verif/link_test_loss_rtt_monitor_checker.sv =====
`timescale 1ns / 1ps

module link_test_loss_rtt_monitor_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  frame_length_i,
  input  logic [7:0]  magic_byte_i,
  input  logic [7:0]  frame_type_i,
  input  logic [31:0] sequence_in_i,
  input  logic [31:0] now_us_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  status_i,
  input  logic [31:0] sequence_out_i,
  input  logic [31:0] round_trip_us_i,
  input  logic [31:0] received_count_i,
  input  logic [31:0] test_received_count_i,
  input  logic [31:0] lost_count_i,
  input  logic [31:0] echo_count_i,
  input  logic [63:0] rtt_total_us_i,
  input  logic [31:0] rtt_least_us_i,
  input  logic [31:0] rtt_most_us_i,
  input  logic [31:0] test_sent_count_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned echo_hits_o
);

  localparam int unsigned SLOTS      = ltm_pkg::RTT_SLOTS_DEF;
  localparam int unsigned MAX_PRINTS = 40;

  typedef struct packed {
    ltm_pkg::status_e status;
    logic [31:0]      seq;
    logic [31:0]      rtt;
    logic [31:0]      rx_frames;
    logic [31:0]      rx_tests;
    logic [31:0]      lost;
    logic [31:0]      echoes;
    logic [63:0]      rtt_sum;
    logic [31:0]      rtt_min;
    logic [31:0]      rtt_max;
    logic [31:0]      sent;
  } link_stats_t;

  link_stats_t stats_q[$];
  link_stats_t want;

  logic [31:0] send_seq;
  logic [31:0] last_seq;
  logic        have_seq;
  logic [31:0] slot_seq   [SLOTS];
  logic [31:0] slot_stamp [SLOTS];
  logic [31:0] rx_frames, rx_tests, lost_frames, echoes, rtt_min, rtt_max, sent_frames;
  logic [63:0] rtt_sum;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
    echo_hits_o  = 0;
  end

  function automatic void clear_stats();
    rx_frames   = '0;
    rx_tests    = '0;
    lost_frames = '0;
    echoes      = '0;
    rtt_sum     = '0;
    rtt_min     = '0;
    rtt_max     = '0;
    sent_frames = '0;
    have_seq    = 1'b0;
  endfunction

  function automatic link_stats_t take_event(input logic [1:0] op, input logic [7:0] len,
                                             input logic [7:0] magic, input logic [7:0] ftype,
                                             input logic [31:0] seq, input logic [31:0] now);
    link_stats_t r;
    int unsigned idx;
    logic [31:0] next_seq;
    r        = '0;
    r.status = ltm_pkg::ST_CLEARED;
    if (op == ltm_pkg::OP_RECV) begin
      rx_frames = rx_frames + 32'd1;
      if (len < ltm_pkg::LEN_TEST_MIN || magic != ltm_pkg::MAGIC_L ||
          (ftype != ltm_pkg::TYPE_T && ftype != ltm_pkg::TYPE_E &&
           ftype != ltm_pkg::TYPE_R)) begin
        r.status = ltm_pkg::ST_APP;
      end else if (len < ltm_pkg::LEN_NUM_MIN) begin
        r.status = ltm_pkg::ST_SHORT;
      end else if (ftype == ltm_pkg::TYPE_R) begin
        idx = seq % SLOTS;
        if (slot_seq[idx] != seq) begin
          r.status = ltm_pkg::ST_UNMATCHED;
        end else begin
          r.rtt   = now - slot_stamp[idx];
          echoes  = echoes + 32'd1;
          rtt_sum = rtt_sum + {32'd0, r.rtt};
          if (rtt_min == 32'd0 || r.rtt < rtt_min) rtt_min = r.rtt;
          if (r.rtt > rtt_max) rtt_max = r.rtt;
          r.status = ltm_pkg::ST_MATCHED;
        end
      end else begin
        rx_tests = rx_tests + 32'd1;
        next_seq = last_seq + 32'd1;
        // gap arithmetic wraps at 32 bits
        if (have_seq && seq > next_seq) lost_frames = lost_frames + (seq - last_seq - 32'd1);
        if (!have_seq || seq > last_seq) begin
          last_seq = seq;
          have_seq = 1'b1;
        end
        if (ftype == ltm_pkg::TYPE_E) begin
          r.seq    = seq;
          r.status = ltm_pkg::ST_ECHO_DUE;
        end else begin
          r.status = ltm_pkg::ST_COUNTED;
        end
      end
    end else if (op == ltm_pkg::OP_SEND) begin
      send_seq = send_seq + 32'd1;
      idx = send_seq % SLOTS;
      slot_seq[idx]   = send_seq;
      slot_stamp[idx] = now;
      sent_frames = sent_frames + 32'd1;
      r.seq    = send_seq;
      r.status = ltm_pkg::ST_SENT;
    end else begin
      clear_stats();
    end
    r.rx_frames = rx_frames;
    r.rx_tests  = rx_tests;
    r.lost      = lost_frames;
    r.echoes    = echoes;
    r.rtt_sum   = rtt_sum;
    r.rtt_min   = rtt_min;
    r.rtt_max   = rtt_max;
    r.sent      = sent_frames;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_v);
    fail_count_o++;
    if (fail_count_o <= MAX_PRINTS)
      $display("%0t: %s: got %h, predicted %h", $realtime, what, got, exp_v);
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] exp_v);
    if (got !== exp_v) report_mismatch(what, got, exp_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_seq = '0;
      last_seq = '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_seq[i]   = '0;
        slot_stamp[i] = '0;
      end
      clear_stats();
      stats_q.delete();
    end else begin
      // compare first: a result beat never belongs to the input beat of the same edge
      if (out_valid_i && out_ready_i) begin
        if (stats_q.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", {61'd0, status_i}, '0);
        end else begin
          want = stats_q.pop_front();
          check_field("status", status_i, want.status);
          check_field("sequence_out", sequence_out_i, want.seq);
          check_field("round_trip_us", round_trip_us_i, want.rtt);
          check_field("received_count", received_count_i, want.rx_frames);
          check_field("test_received_count", test_received_count_i, want.rx_tests);
          check_field("lost_count", lost_count_i, want.lost);
          check_field("echo_count", echo_count_i, want.echoes);
          check_field("rtt_total_us", rtt_total_us_i, want.rtt_sum);
          check_field("rtt_least_us", rtt_least_us_i, want.rtt_min);
          check_field("rtt_most_us", rtt_most_us_i, want.rtt_max);
          check_field("test_sent_count", test_sent_count_i, want.sent);
          checked_o++;
          if (want.status == ltm_pkg::ST_MATCHED) echo_hits_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (operation_i)
          ltm_pkg::OP_RECV, ltm_pkg::OP_SEND, ltm_pkg::OP_CLEAR: begin
            stats_q.push_back(take_event(operation_i, frame_length_i, magic_byte_i,
                                         frame_type_i, sequence_in_i, now_us_i));
          end
          default: ;
        endcase
      end
    end
    pending_o = stats_q.size();
  end

endmodule

// ===== verif/link_test_loss_rtt_monitor_top_tb.sv =====
`timescale 1ns / 1ps

module link_test_loss_rtt_monitor_top_tb;

  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam int unsigned RANDOM_BEATS   = 850;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [1:0]  operation    = ltm_pkg::OP_RECV;
  logic [7:0]  frame_length = '0;
  logic [7:0]  magic_byte   = '0;
  logic [7:0]  frame_type   = '0;
  logic [31:0] sequence_in  = '0;
  logic [31:0] now_us       = '0;
  logic        out_ready    = 1'b0;

  logic        in_ready;
  logic        out_valid;
  logic [2:0]  status;
  logic [31:0] sequence_out, round_trip_us, received_count, test_received_count;
  logic [31:0] lost_count, echo_count, rtt_least_us, rtt_most_us, test_sent_count;
  logic [63:0] rtt_total_us;

  int unsigned fail_count, pending, checked, echo_hits;
  int unsigned tx_idle_pct = 15;
  int unsigned rx_idle_pct = 77;
  int unsigned beats_in    = 0;
  int unsigned idle_cycles = 0;
  bit          hold_req    = 1'b0;
  logic [31:0] sends_done  = '0;
  logic [31:0] peer_seq    = '0;
  logic [31:0] clock_us    = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  link_test_loss_rtt_monitor_top dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready),
    .operation_i           (operation),
    .frame_length_i        (frame_length),
    .magic_byte_i          (magic_byte),
    .frame_type_i          (frame_type),
    .sequence_in_i         (sequence_in),
    .now_us_i              (now_us),
    .out_valid_o           (out_valid),
    .out_ready_i           (out_ready),
    .status_o              (status),
    .sequence_out_o        (sequence_out),
    .round_trip_us_o       (round_trip_us),
    .received_count_o      (received_count),
    .test_received_count_o (test_received_count),
    .lost_count_o          (lost_count),
    .echo_count_o          (echo_count),
    .rtt_total_us_o        (rtt_total_us),
    .rtt_least_us_o        (rtt_least_us),
    .rtt_most_us_o         (rtt_most_us),
    .test_sent_count_o     (test_sent_count)
  );

  link_test_loss_rtt_monitor_checker stats_check (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_ready_i            (in_ready),
    .operation_i           (operation),
    .frame_length_i        (frame_length),
    .magic_byte_i          (magic_byte),
    .frame_type_i          (frame_type),
    .sequence_in_i         (sequence_in),
    .now_us_i              (now_us),
    .out_valid_i           (out_valid),
    .out_ready_i           (out_ready),
    .status_i              (status),
    .sequence_out_i        (sequence_out),
    .round_trip_us_i       (round_trip_us),
    .received_count_i      (received_count),
    .test_received_count_i (test_received_count),
    .lost_count_i          (lost_count),
    .echo_count_i          (echo_count),
    .rtt_total_us_i        (rtt_total_us),
    .rtt_least_us_i        (rtt_least_us),
    .rtt_most_us_i         (rtt_most_us),
    .test_sent_count_i     (test_sent_count),
    .fail_count_o          (fail_count),
    .pending_o             (pending),
    .checked_o             (checked),
    .echo_hits_o           (echo_hits)
  );

  // receiver: random backpressure, plus one long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic put_beat(input logic [1:0] op, input logic [7:0] len, input logic [7:0] magic,
                          input logic [7:0] ftype, input logic [31:0] seq,
                          input logic [31:0] now);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    frame_length <= len;
    magic_byte   <= magic;
    frame_type   <= ftype;
    sequence_in  <= seq;
    now_us       <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == ltm_pkg::OP_SEND) sends_done = sends_done + 32'd1;
    beats_in++;
  endtask

  task automatic random_beat(output bit counted);
    int unsigned pick;
    logic [1:0]  op;
    logic [7:0]  len, magic, ftype;
    logic [31:0] seq, now;
    pick     = $urandom_range(99);
    clock_us = clock_us + $urandom_range(1, 4000);
    now      = ($urandom_range(15) == 0) ? $urandom : clock_us;
    op       = ltm_pkg::OP_RECV;
    len      = 8'($urandom_range(6, 250));
    magic    = ltm_pkg::MAGIC_L;
    ftype    = ltm_pkg::TYPE_T;
    seq      = $urandom;
    if (pick < 34) begin
      // numbered frames: mostly in order, some gaps, repeats and jumps
      case ($urandom_range(9))
        0: seq = peer_seq - $urandom_range(0, 3);
        1: begin
          peer_seq = $urandom;
          seq      = peer_seq;
        end
        2, 3: begin
          peer_seq = peer_seq + $urandom_range(2, 9);
          seq      = peer_seq;
        end
        default: begin
          peer_seq = peer_seq + 32'd1;
          seq      = peer_seq;
        end
      endcase
      if ($urandom_range(2) == 0) ftype = ltm_pkg::TYPE_E;
    end else if (pick < 54) begin
      // echo of a recent send; older ones have been overwritten in the slot table
      ftype = ltm_pkg::TYPE_R;
      if ($urandom_range(9) != 0) seq = sends_done - $urandom_range(0, 72);
    end else if (pick < 78) begin
      op = ltm_pkg::OP_SEND;
    end else if (pick < 81) begin
      op = ltm_pkg::OP_CLEAR;
    end else if (pick < 84) begin
      op = OP_UNUSED;
    end else if (pick < 91) begin
      len = 8'($urandom_range(0, 5));
      case ($urandom_range(2))
        0:       ftype = ltm_pkg::TYPE_T;
        1:       ftype = ltm_pkg::TYPE_E;
        default: ftype = ltm_pkg::TYPE_R;
      endcase
    end else begin
      len   = 8'($urandom);
      magic = ($urandom_range(1) == 0) ? ltm_pkg::MAGIC_L : 8'($urandom);
      ftype = 8'($urandom);
    end
    if (op != ltm_pkg::OP_RECV) begin
      len   = 8'($urandom);
      magic = 8'($urandom);
      ftype = 8'($urandom);
    end
    put_beat(op, len, magic, ftype, seq, now);
    counted = (op != OP_UNUSED);
  endtask

  initial begin
    int unsigned random_done;
    bit          counted;
    bit          hold_done;
    random_done = 0;
    hold_done   = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // echo of sequence 0 hits the zeroed slot 0
    put_beat(ltm_pkg::OP_RECV, 8'd6, ltm_pkg::MAGIC_L, ltm_pkg::TYPE_R, 32'd0, 32'd100);
    put_beat(ltm_pkg::OP_RECV, 8'd0, 8'h00, 8'h00, 32'd0, 32'd0);
    put_beat(ltm_pkg::OP_RECV, 8'd255, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_beat(ltm_pkg::OP_RECV, 8'd1, ltm_pkg::MAGIC_L, ltm_pkg::TYPE_T, 32'd3, 32'd0);
    put_beat(ltm_pkg::OP_RECV, 8'd8, ltm_pkg::MAGIC_L, 8'h41, 32'd3, 32'd0);
    put_beat(ltm_pkg::OP_RECV, 8'd5, ltm_pkg::MAGIC_L, ltm_pkg::TYPE_T, 32'd3, 32'd0);
    put_beat(ltm_pkg::OP_RECV, 8'd2, ltm_pkg::MAGIC_L, ltm_pkg::TYPE_R, 32'd0, 32'd0);
    put_beat(ltm_pkg::OP_RECV, 8'd6, ltm_pkg::MAGIC_L, ltm_pkg::TYPE_T, 32'd10, 32'd0);
    put_beat(ltm_pkg::OP_RECV, 8'd6, ltm_pkg::MAGIC_L, ltm_pkg::TYPE_T, 32'd14, 32'd0);
    put_beat(ltm_pkg::OP_RECV, 8'd6, ltm_pkg::MAGIC_L, ltm_pkg::TYPE_T, 32'd12, 32'd0);
    put_beat(ltm_pkg::OP_RECV, 8'd7, ltm_pkg::MAGIC_L, ltm_pkg::TYPE_E, 32'd14, 32'd0);
    put_beat(ltm_pkg::OP_RECV, 8'd250, ltm_pkg::MAGIC_L, ltm_pkg::TYPE_E, 32'd15, 32'd0);
    put_beat(ltm_pkg::OP_RECV, 8'd6, ltm_pkg::MAGIC_L, ltm_pkg::TYPE_T, 32'hFFFF_FFFF, 32'd0);
    put_beat(ltm_pkg::OP_RECV, 8'd6, ltm_pkg::MAGIC_L, ltm_pkg::TYPE_T, 32'd0, 32'd0);
    put_beat(ltm_pkg::OP_SEND, 8'd0, 8'h00, 8'h00, 32'd0, 32'd1000);
    put_beat(ltm_pkg::OP_SEND, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
    put_beat(ltm_pkg::OP_RECV, 8'd6, ltm_pkg::MAGIC_L, ltm_pkg::TYPE_R, 32'd1, 32'd1500);
    put_beat(ltm_pkg::OP_RECV, 8'd6, ltm_pkg::MAGIC_L, ltm_pkg::TYPE_R, 32'd2, 32'h0000_0010);
    put_beat(ltm_pkg::OP_RECV, 8'd6, ltm_pkg::MAGIC_L, ltm_pkg::TYPE_R, 32'd3, 32'd0);
    put_beat(ltm_pkg::OP_RECV, 8'd6, ltm_pkg::MAGIC_L, ltm_pkg::TYPE_R, 32'd65, 32'd0);
    put_beat(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_beat(ltm_pkg::OP_CLEAR, 8'd0, 8'h00, 8'h00, 32'd0, 32'd0);
    put_beat(ltm_pkg::OP_RECV, 8'd6, ltm_pkg::MAGIC_L, ltm_pkg::TYPE_T, 32'hFFFF_FFFE, 32'd0);
    put_beat(ltm_pkg::OP_RECV, 8'd6, ltm_pkg::MAGIC_L, ltm_pkg::TYPE_R, 32'd1, 32'd1000);
    put_beat(ltm_pkg::OP_SEND, 8'd0, 8'h00, 8'h00, 32'd0, 32'h8000_0000);

    while (random_done < RANDOM_BEATS) begin
      if (random_done < RANDOM_BEATS / 3) begin
        tx_idle_pct = 15;
        rx_idle_pct = 77;
      end else if (random_done < 2 * RANDOM_BEATS / 3) begin
        tx_idle_pct = 77;
        rx_idle_pct = 15;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // hold the output while beats keep coming, so the input stalls
        if (!hold_done) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
      end
      random_beat(counted);
      if (counted) random_done++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run drove %0d input beats (%0d random) and checked %0d result beats.",
             beats_in, random_done, checked);
    $display("Echoes matched: %0d, test frames sent: %0d, mismatches: %0d.",
             echo_hits, sends_done, fail_count);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== link_test_loss_rtt_monitor_top.f =====
sv/ltm_pkg.sv
sv/ltm_front.sv
sv/ltm_queue.sv
sv/ltm_back.sv
sv/link_test_loss_rtt_monitor_top.sv
verif/link_test_loss_rtt_monitor_checker.sv
verif/link_test_loss_rtt_monitor_top_tb.sv
